// ===== src/rpli_pkg.sv =====
// ----------------------------------------------------------------------------
// rpli_pkg
// Shared widths, command codes and register indexes of the return period
// loss interpolator.
// ----------------------------------------------------------------------------
package rpli_pkg;

   localparam int unsigned GROUP_W = 16;
   localparam int unsigned LOSS_W  = 32;
   localparam int unsigned RP_W    = 32;    // Q24.8 return period
   localparam int unsigned CFG_W   = 24;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned CSR_A_W = 3;

   // request commands
   localparam logic CMD_LOSS  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_TOTAL_PERIODS = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_TABLE_COUNT   = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_RP_TABLE_BASE = 3'd2;

   localparam logic [LOSS_W-1:0] LOSS_MAX = '1;
   localparam logic [CFG_W-1:0]  RANK_MAX = '1;

   typedef logic [RP_W-1:0] rp_type;

endpackage

// ===== src/return_period_loss_interpolator.sv =====
// ----------------------------------------------------------------------------
// return_period_loss_interpolator
// Turns descending per-group losses into exceedance curve points, either
// directly or interpolated at a table of requested return periods.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  req      in   req_valid/ready    command, group_id, loss
//  rsp      out  rsp_valid/ready    out_group, period (Q24.8), point_loss,
//                                   last_of_run
//  csr      in   csr_wr_en          csr_index, csr_wdata
//
//  A loss request first forms its return period (one radix-2 divide step a
//  cycle, 32 steps), then walks the table: an exact point goes straight to
//  output, an interpolated one through a multiply, a range check and, if in
//  range, a divide. A flush walks the remaining table points. All division runs through the one
//  restoring divide unit. Reset is synchronous and loads the register
//  defaults at once. rsp_ready low holds the sequencer before it loads the
//  next result; the final result of a request waits in the output register
//  while the next request is taken.
// ----------------------------------------------------------------------------
module return_period_loss_interpolator #(
   parameter int unsigned RP_SLOTS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [rpli_pkg::GROUP_W-1:0]       req_group_id,
   input  logic [rpli_pkg::LOSS_W-1:0]        req_loss,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rpli_pkg::GROUP_W-1:0]       rsp_out_group,
   output logic [rpli_pkg::RP_W-1:0]          rsp_return_period,
   output logic [rpli_pkg::LOSS_W-1:0]        rsp_point_loss,
   output logic                               rsp_last_of_run,
   input  logic                               csr_wr_en,
   input  logic [rpli_pkg::CSR_A_W-1:0]       csr_index,
   input  logic [rpli_pkg::CFG_W-1:0]         csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_PRE  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   localparam logic [rpli_pkg::CNT_W-1:0] SLOT_LIMIT = rpli_pkg::CNT_W'(RP_SLOTS);
   localparam logic [4:0] LAST_STEP = 5'd31;

   // control state
   logic [2:0]                        state_ff, state_in;
   logic [rpli_pkg::CFG_W-1:0]        rank_ff, rank_in;
   logic [rpli_pkg::CNT_W-1:0]        idx_ff, idx_in;
   rpli_pkg::rp_type                  prev_rp_ff, prev_rp_in;
   logic [rpli_pkg::LOSS_W-1:0]       prev_loss_ff, prev_loss_in;
   logic                              flush_ff, flush_in;
   logic                              direct_ff, direct_in;
   logic                              loss_div_ff, loss_div_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [rpli_pkg::CFG_W-1:0]        total_ff, total_in;
   logic [rpli_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [rpli_pkg::CFG_W-1:0]        rp_ff [RP_SLOTS];
   logic [rpli_pkg::CFG_W-1:0]        rp_in [RP_SLOTS];

   // datapath
   rpli_pkg::rp_type                  cur_ff, cur_in;
   logic [rpli_pkg::LOSS_W-1:0]       loss_ff, loss_in;
   logic [rpli_pkg::GROUP_W-1:0]      grp_ff, grp_in;
   logic [31:0]                       rem_ff, rem_in;
   logic [31:0]                       dq_ff, dq_in;
   logic [31:0]                       dvs_ff, dvs_in;
   logic [4:0]                        step_ff, step_in;
   logic [63:0]                       prod_ff, prod_in;
   logic [rpli_pkg::LOSS_W-1:0]       res_ff, res_in;
   logic [rpli_pkg::GROUP_W-1:0]      rsp_group_ff, rsp_group_in;
   rpli_pkg::rp_type                  rsp_rp_ff, rsp_rp_in;
   logic [rpli_pkg::LOSS_W-1:0]       rsp_loss_ff, rsp_loss_in;
   logic                              rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic [rpli_pkg::CNT_W-1:0]        cnt_c;
   logic [rpli_pkg::CNT_W-1:0]        nidx_c;
   rpli_pkg::rp_type                  nx_c, nx_next_c;
   logic                              last_c, dneg_c, xneg_c, out_free_c;
   logic [32:0]                       trial_c;
   logic [33:0]                       diff_c;
   logic                              qbit_c;
   logic [31:0]                       rem_next_c, dq_next_c;
   logic [31:0]                       dxr_c, dlm_c, dxm_c;
   logic [32:0]                       sum_c;

   assign cnt_c  = (count_ff > SLOT_LIMIT) ? SLOT_LIMIT : count_ff;
   assign nidx_c = idx_ff + 1'b1;

   always_comb begin
      nx_c      = '0;
      nx_next_c = '0;
      for (int k = 0; k < RP_SLOTS; k++) begin
         if (idx_ff == rpli_pkg::CNT_W'(k)) begin
            nx_c = {rp_ff[k], 8'd0};
         end
         if (nidx_c == rpli_pkg::CNT_W'(k)) begin
            nx_next_c = {rp_ff[k], 8'd0};
         end
      end
   end

   assign last_c = direct_ff || (nidx_c >= cnt_c) || (cur_ff > nx_next_c);

   // slope terms against the previous curve point
   assign dneg_c = prev_loss_ff < loss_ff;
   assign xneg_c = prev_rp_ff < cur_ff;
   assign dxr_c  = nx_c - cur_ff;
   assign dlm_c  = dneg_c ? (loss_ff - prev_loss_ff) : (prev_loss_ff - loss_ff);
   assign dxm_c  = xneg_c ? (cur_ff - prev_rp_ff) : (prev_rp_ff - cur_ff);

   // one restoring divide step
   assign trial_c    = {rem_ff, dq_ff[31]};
   assign diff_c     = {1'b0, trial_c} - {2'b00, dvs_ff};
   assign qbit_c     = ~diff_c[33];
   assign rem_next_c = qbit_c ? diff_c[31:0] : trial_c[31:0];
   assign dq_next_c  = {dq_ff[30:0], qbit_c};

   assign sum_c      = {1'b0, dq_ff} + {1'b0, loss_ff};
   assign out_free_c = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      idx_in       = idx_ff;
      prev_rp_in   = prev_rp_ff;
      prev_loss_in = prev_loss_ff;
      flush_in     = flush_ff;
      direct_in    = direct_ff;
      loss_div_in  = loss_div_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      total_in     = total_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      cur_in       = cur_ff;
      loss_in      = loss_ff;
      grp_in       = grp_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_group_in = rsp_group_ff;
      rsp_rp_in    = rsp_rp_ff;
      rsp_loss_in  = rsp_loss_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         if (csr_index == rpli_pkg::CSR_TOTAL_PERIODS) begin
            total_in = csr_wdata;
         end
         if (csr_index == rpli_pkg::CSR_TABLE_COUNT) begin
            count_in = csr_wdata[rpli_pkg::CNT_W-1:0];
         end
         for (int k = 0; k < RP_SLOTS; k++) begin
            if (csr_index == rpli_pkg::CSR_RP_TABLE_BASE + rpli_pkg::CSR_A_W'(k)) begin
               rp_in[k] = csr_wdata;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               grp_in    = req_group_id;
               loss_in   = req_loss;
               direct_in = 1'b0;
               if (req_command == rpli_pkg::CMD_FLUSH) begin
                  flush_in = 1'b1;
                  cur_in   = '0;
                  state_in = ST_WALK;
               end else begin
                  flush_in    = 1'b0;
                  rank_in     = (rank_ff == rpli_pkg::RANK_MAX) ? rank_ff : rank_ff + 1'b1;
                  rem_in      = '0;
                  dq_in       = {total_ff, 8'd0};
                  dvs_in      = {8'd0, rank_in};
                  step_in     = '0;
                  loss_div_in = 1'b1;
                  state_in    = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in  = rem_next_c;
            dq_in   = dq_next_c;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               if (loss_div_ff) begin
                  cur_in = dq_next_c;
                  if (cnt_c == '0) begin
                     direct_in = 1'b1;
                     state_in  = ST_EMIT;
                  end else begin
                     state_in  = ST_WALK;
                  end
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_WALK: begin
            if ((idx_ff < cnt_c) && !(cur_ff > nx_c)) begin
               if (cur_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_EMIT;
               end else if ((cur_ff == nx_c) || (prev_rp_ff == cur_ff)) begin
                  res_in   = loss_ff;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_MUL;
               end
            end else begin
               // no table point reached: close out the request
               if (cur_ff != '0) begin
                  prev_rp_in   = cur_ff;
                  prev_loss_in = loss_ff;
               end
               if (flush_ff) begin
                  rank_in      = '0;
                  idx_in       = '0;
                  prev_rp_in   = '0;
                  prev_loss_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            prod_in  = 64'(dxr_c) * 64'(dlm_c);
            dvs_in   = dxm_c;
            state_in = ST_PRE;
         end
         ST_PRE: begin
            // high half at or above the divisor: quotient exceeds any loss
            if (prod_ff[63:32] >= dvs_ff) begin
               res_in   = (dneg_c != xneg_c) ? '0 : rpli_pkg::LOSS_MAX;
               state_in = ST_EMIT;
            end else begin
               rem_in      = prod_ff[63:32];
               dq_in       = prod_ff[31:0];
               step_in     = '0;
               loss_div_in = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_FIN: begin
            if (dneg_c != xneg_c) begin
               res_in = (dq_ff >= loss_ff) ? '0 : loss_ff - dq_ff;
            end else begin
               res_in = sum_c[32] ? rpli_pkg::LOSS_MAX : sum_c[31:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free_c) begin
               rsp_valid_in = 1'b1;
               rsp_group_in = grp_ff;
               rsp_rp_in    = direct_ff ? cur_ff : nx_c;
               rsp_loss_in  = direct_ff ? loss_ff : res_ff;
               rsp_last_in  = last_c;
               if (!direct_ff) begin
                  idx_in = nidx_c;
               end
               if (last_c) begin
                  if (!direct_ff && (cur_ff != '0)) begin
                     prev_rp_in   = cur_ff;
                     prev_loss_in = loss_ff;
                  end
                  if (flush_ff) begin
                     rank_in      = '0;
                     idx_in       = '0;
                     prev_rp_in   = '0;
                     prev_loss_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rank_ff      <= '0;
         idx_ff       <= '0;
         prev_rp_ff   <= '0;
         prev_loss_ff <= '0;
         flush_ff     <= 1'b0;
         direct_ff    <= 1'b0;
         loss_div_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= rpli_pkg::CFG_W'(1);
         count_ff     <= '0;
         for (int k = 0; k < RP_SLOTS; k++) begin
            rp_ff[k] <= rpli_pkg::CFG_W'(1);
         end
      end else begin
         state_ff     <= state_in;
         rank_ff      <= rank_in;
         idx_ff       <= idx_in;
         prev_rp_ff   <= prev_rp_in;
         prev_loss_ff <= prev_loss_in;
         flush_ff     <= flush_in;
         direct_ff    <= direct_in;
         loss_div_ff  <= loss_div_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      loss_ff      <= loss_in;
      grp_ff       <= grp_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      dvs_ff       <= dvs_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      rsp_group_ff <= rsp_group_in;
      rsp_rp_ff    <= rsp_rp_in;
      rsp_loss_ff  <= rsp_loss_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_group     = rsp_group_ff;
   assign rsp_return_period = rsp_rp_ff;
   assign rsp_point_loss    = rsp_loss_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

// ===== src/rpli_checker.sv =====
// ----------------------------------------------------------------------------
// rpli_checker
// Port-level checks of the return period loss interpolator, bound to the
// top level.
// ----------------------------------------------------------------------------
module rpli_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rpli_pkg::GROUP_W-1:0]       rsp_out_group,
   input logic [rpli_pkg::RP_W-1:0]          rsp_return_period,
   input logic [rpli_pkg::LOSS_W-1:0]        rsp_point_loss,
   input logic                               rsp_last_of_run
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_group)
         && $stable(rsp_return_period) && $stable(rsp_point_loss)
         && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   // idle only once the final result of a request is loaded
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last_of_run)
      else $error("idle with a non-final result pending");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind return_period_loss_interpolator rpli_checker u_rpli_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_group     (rsp_out_group),
   .rsp_return_period (rsp_return_period),
   .rsp_point_loss    (rsp_point_loss),
   .rsp_last_of_run   (rsp_last_of_run)
);
